[sv/linear_probe_hash_map_core_defines.svh]
// assertion macros used by the checker file of the hash map core
// depends on nothing; the user file supplies clk and rst_n in scope
`ifndef LINEAR_PROBE_HASH_MAP_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_CORE_DEFINES_SVH

// concurrent check, masked while reset is low
`define LPHM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent check that also runs through reset
`define LPHM_CHECK_RAW(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[sv/lphm_pkg.sv]
// shared types and constants of the linear probe hash map core
// no dependencies
`default_nettype none

package lphm_pkg;

    localparam int REQ_W  = 2;
    localparam int KEY_W  = 64;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 9;
    localparam int SLOT_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // response status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    // slot state codes
    localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_USED  = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_TOMB  = 2'd2;

    localparam logic [CNT_W-1:0] LOAD_LIMIT_RST = 9'd192;

    // splitmix64 finalizer
    localparam logic [KEY_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    typedef enum logic [2:0] {
        MIX_P0_LL,
        MIX_P0_LH,
        MIX_P0_HL,
        MIX_FOLD,
        MIX_P1_LL,
        MIX_P1_LH,
        MIX_P1_HL,
        MIX_DONE
    } lphm_mix_step_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_APPLY
    } lphm_state_t;

endpackage

`default_nettype wire

[sv/lphm_if.sv]
// valid/ready channel interfaces: request, response and config write
// depends on lphm_pkg
`default_nettype none

interface lphm_req_if;
    import lphm_pkg::*;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   value_in;

    modport source (output valid, req_type, key, value_in, input ready);
    modport sink   (input valid, req_type, key, value_in, output ready);
endinterface

interface lphm_rsp_if;
    import lphm_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [DATA_W-1:0]   value_out;
    logic [CNT_W-1:0]    entry_total;

    modport source (output valid, status, value_out, entry_total, input ready);
    modport sink   (input valid, status, value_out, entry_total, output ready);
endinterface

interface lphm_cfg_if;
    import lphm_pkg::*;
    logic                valid;
    logic                ready;
    logic [CNT_W-1:0]    load_limit;

    modport source (output valid, load_limit, input ready);
    modport sink   (input valid, load_limit, output ready);
endinterface

`default_nettype wire

[sv/lphm_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/lphm_mix.sv]
// splitmix64 finalizer on one shared 32x32 multiplier
// depends on lphm_pkg
`default_nettype none

module lphm_mix (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lphm_pkg::KEY_W-1:0] x,
    output      logic                       done,
    output      logic [lphm_pkg::KEY_W-1:0] hash
);
    import lphm_pkg::*;

    lphm_mix_step_t     step_reg, step_next;
    logic               busy_reg, busy_next;
    logic [KEY_W-1:0]   z_reg, z_next;
    logic [KEY_W-1:0]   acc_reg, acc_next;
    logic [31:0]        mul_a, mul_b;
    logic [KEY_W-1:0]   prod;

    assign prod = KEY_W'(mul_a) * KEY_W'(mul_b);
    assign hash = acc_reg ^ (acc_reg >> MIX_SH2);
    assign done = busy_reg && (step_reg == MIX_DONE);

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        z_next    = z_reg;
        acc_next  = acc_reg;
        mul_a     = z_reg[31:0];
        mul_b     = MIX_C1[31:0];
        case (step_reg)
            MIX_P0_LL:
            begin
                acc_next = prod;
            end
            MIX_P0_LH:
            begin
                mul_b    = MIX_C1[63:32];
                acc_next = acc_reg + {prod[31:0], 32'b0};
            end
            MIX_P0_HL:
            begin
                mul_a    = z_reg[63:32];
                acc_next = acc_reg + {prod[31:0], 32'b0};
            end
            MIX_FOLD:
            begin
                z_next = acc_reg ^ (acc_reg >> MIX_SH1);
            end
            MIX_P1_LL:
            begin
                mul_b    = MIX_C2[31:0];
                acc_next = prod;
            end
            MIX_P1_LH:
            begin
                mul_b    = MIX_C2[63:32];
                acc_next = acc_reg + {prod[31:0], 32'b0};
            end
            MIX_P1_HL:
            begin
                mul_a    = z_reg[63:32];
                mul_b    = MIX_C2[31:0];
                acc_next = acc_reg + {prod[31:0], 32'b0};
            end
            default:
            begin
                busy_next = 1'b0;
            end
        endcase
        if (step_reg != MIX_DONE)
        begin
            step_next = lphm_mix_step_t'(3'(step_reg + 3'd1));
        end
        if (!busy_reg)
        begin
            z_next    = z_reg;
            acc_next  = acc_reg;
            step_next = step_reg;
            busy_next = 1'b0;
        end
        if (start)
        begin
            z_next    = x ^ (x >> MIX_SH0);
            step_next = MIX_P0_LL;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= MIX_P0_LL;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg   <= z_next;
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

[sv/linear_probe_hash_map_core.sv]
// Open-addressing hash map with 64-bit keys and linear probing.
// Channels: req (sink) takes one word {req_type, key, value_in}; rsp (source)
// returns one word {status, value_out, entry_total} per request; cfg (sink)
// writes load_limit and is always ready.
// Steps: the request is accepted in idle, hashed with splitmix64 on the
// shared 32x32 multiplier, then probed slot by slot (one read of the slot
// ram per cycle), then applied: the slot is updated and the response
// register loaded.
// Flow: one request in flight; req.ready is high only when the core is idle,
// so the next request is taken once the previous one has been applied, even
// while its response still waits in the output register.
// Reset: occupied count cleared, load_limit back to 192, then a clearing
// pass writes every slot empty with req.ready held low.
// Stall: if rsp.ready is low, the next request is still hashed and probed
// but waits before applying until the output register has been taken.
// SLOTS must be a power of two.
`default_nettype none

module linear_probe_hash_map_core #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lphm_req_if.sink    req,
    lphm_rsp_if.source  rsp,
    lphm_cfg_if.sink    cfg
);
    import lphm_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int VAL_W  = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
    localparam int WORD_W = SLOT_W + KEY_W + VAL_W;

    // control
    lphm_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   load_limit_reg, load_limit_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               hit_found_reg, hit_found_next;
    logic               free_found_reg, free_found_next;

    // request and probe payload
    logic [REQ_W-1:0]   req_type_reg, req_type_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]   probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [VAL_W-1:0]   hit_val_reg, hit_val_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    // response payload
    logic [STAT_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [DATA_W-1:0]  rsp_value_reg, rsp_value_next;
    logic [CNT_W-1:0]   rsp_total_reg, rsp_total_next;

    // slot ram
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    logic [SLOT_W-1:0]  rd_state;
    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic [SLOT_W-1:0]  wr_state;
    logic               probe_stop;

    // hash unit
    logic               mix_start, mix_done;
    logic [KEY_W-1:0]   mix_hash;

    lphm_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .x     (req.key),
        .done  (mix_done),
        .hash  (mix_hash)
    );

    // one word per slot: {state, key, value}
    lphm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_state = ram_rdata[WORD_W-1 -: SLOT_W];
    assign rd_key   = ram_rdata[VAL_W +: KEY_W];
    assign rd_val   = ram_rdata[VAL_W-1:0];

    assign req.ready       = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.value_out   = rsp_value_reg;
    assign rsp.entry_total = rsp_total_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        count_next      = count_reg;
        load_limit_next = cfg.valid ? cfg.load_limit : load_limit_reg;
        rsp_valid_next  = rsp_valid_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        req_type_next   = req_type_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        chk_idx_next    = chk_idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        free_idx_next   = free_idx_reg;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_total_next  = rsp_total_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_idx_reg;
        wr_state        = SLOT_EMPTY;
        ram_wdata       = {SLOT_EMPTY, {(KEY_W + VAL_W){1'b0}}};
        ram_re          = 1'b0;
        ram_raddr       = IDX_W'(chk_idx_reg + 1'b1);
        mix_start       = 1'b0;
        probe_stop      = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // write every slot empty, one per cycle
                ram_we       = 1'b1;
                clr_idx_next = IDX_W'(clr_idx_reg + 1'b1);
                if (clr_idx_reg == {IDX_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mix_start     = 1'b1;
                    req_type_next = req.req_type;
                    key_next      = req.key;
                    val_next      = req.value_in[VAL_W-1:0];
                    state_next    = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mix_done)
                begin
                    // home slot is the low hash bits
                    ram_re          = 1'b1;
                    ram_raddr       = mix_hash[IDX_W-1:0];
                    chk_idx_next    = mix_hash[IDX_W-1:0];
                    probe_cnt_next  = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // ram data belongs to chk_idx_reg; the next slot read is issued only if the probe goes on
                if (rd_state == SLOT_EMPTY)
                begin
                    if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    probe_stop = 1'b1;
                end
                else if (rd_state == SLOT_USED)
                begin
                    if (rd_key == key_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_val_next   = rd_val;
                        probe_stop     = 1'b1;
                    end
                end
                else if (!free_found_reg)
                begin
                    // first tombstone passed
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
                // wrapped all the way around
                if (probe_cnt_reg == {IDX_W{1'b1}})
                begin
                    probe_stop = 1'b1;
                end
                if (probe_stop)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    ram_re         = 1'b1;
                    chk_idx_next   = IDX_W'(chk_idx_reg + 1'b1);
                    probe_cnt_next = IDX_W'(probe_cnt_reg + 1'b1);
                end
            end
            ST_APPLY:
            begin
                // wait for a free output register
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = STAT_MISS;
                    rsp_value_next  = '0;
                    ram_waddr       = hit_idx_reg;
                    wr_state        = SLOT_USED;
                    case (req_type_reg)
                        REQ_SET:
                        begin
                            if (hit_found_reg)
                            begin
                                ram_we          = 1'b1;
                                rsp_status_next = STAT_OK;
                            end
                            else if (count_reg >= load_limit_reg || !free_found_reg)
                            begin
                                rsp_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = free_idx_reg;
                                count_next      = CNT_W'(count_reg + 1'b1);
                                rsp_status_next = STAT_OK;
                            end
                        end
                        REQ_GET:
                        begin
                            if (hit_found_reg)
                            begin
                                rsp_status_next = STAT_OK;
                                rsp_value_next  = DATA_W'(hit_val_reg);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (hit_found_reg)
                            begin
                                ram_we          = 1'b1;
                                wr_state        = SLOT_TOMB;
                                rsp_status_next = STAT_OK;
                                if (count_reg != '0)
                                begin
                                    count_next = CNT_W'(count_reg - 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            rsp_status_next = STAT_MISS;
                        end
                    endcase
                    ram_wdata      = {wr_state, key_reg, val_reg};
                    rsp_total_next = count_next;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            count_reg      <= '0;
            load_limit_reg <= LOAD_LIMIT_RST;
            rsp_valid_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            count_reg      <= count_next;
            load_limit_reg <= load_limit_next;
            rsp_valid_reg  <= rsp_valid_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        chk_idx_reg    <= chk_idx_next;
        probe_cnt_reg  <= probe_cnt_next;
        hit_idx_reg    <= hit_idx_next;
        hit_val_reg    <= hit_val_next;
        free_idx_reg   <= free_idx_next;
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_total_reg  <= rsp_total_next;
    end

endmodule

`default_nettype wire

[sv/lphm_checker.sv]
// port-level checks for the hash map core, bound onto the top level
// depends on lphm_pkg and linear_probe_hash_map_core_defines.svh
`default_nettype none
`include "linear_probe_hash_map_core_defines.svh"

module lphm_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [lphm_pkg::STAT_W-1:0] rsp_status,
    input wire logic [lphm_pkg::DATA_W-1:0] rsp_value_out,
    input wire logic [lphm_pkg::CNT_W-1:0]  rsp_entry_total
);
    import lphm_pkg::*;

    // stalled response word holds
    `LPHM_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value_out) && $stable(rsp_entry_total), "response word changed while stalled")

    // failed requests return zero data
    `LPHM_CHECK(a_value_zero, rsp_valid && rsp_status != STAT_OK |-> rsp_value_out == '0, "value_out nonzero on a failed request")

    // one request in flight
    `LPHM_CHECK(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "request taken while busy")

    // clearing pass follows reset
    `LPHM_CHECK_RAW(a_clear_after_reset, !rst_n |=> !req_ready, "ready high right after reset")

endmodule

bind linear_probe_hash_map_core lphm_checker u_lphm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_value_out   (rsp.value_out),
    .rsp_entry_total (rsp.entry_total)
);

`default_nettype wire

[tb/linear_probe_hash_map_core_tb.sv]
// self-checking testbench of linear_probe_hash_map_core: directed and random
// set/get/remove traffic checked against a shadow copy of the slot table
// depends on lphm_pkg, the interfaces in lphm_if.sv and the core itself
`default_nettype none

module linear_probe_hash_map_core_tb;
    import lphm_pkg::*;

    localparam int SLOTS           = 256;
    localparam int VALUE_BITS      = 32;
    localparam int HOLD_CYCLES     = 400;
    // worst quiet gap: clearing pass, a long response hold, full-table probes
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int KEY_POOL_MAX    = 400;

    // the one request code the core does not define
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] value_out;
        logic [CNT_W-1:0]  entry_total;
    } map_answer_t;

    // shadow of the slot table; predicts one answer per accepted request
    class hash_map_shadow;
        logic [SLOT_W-1:0] slot_st [SLOTS];
        logic [KEY_W-1:0]  slot_key [SLOTS];
        logic [DATA_W-1:0] slot_val [SLOTS];
        logic [CNT_W-1:0]  occupied;
        logic [CNT_W-1:0]  load_limit;
        map_answer_t       answers_due[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       req_tally [4];
        int unsigned       stat_tally [4];

        function new();
            foreach (slot_st[i])
            begin
                slot_st[i]  = SLOT_EMPTY;
                slot_key[i] = '0;
                slot_val[i] = '0;
            end
            occupied   = '0;
            load_limit = LOAD_LIMIT_RST;
            mismatches = 0;
            checked    = 0;
            foreach (req_tally[i])
            begin
                req_tally[i]  = 0;
                stat_tally[i] = 0;
            end
        endfunction

        function int home_slot(logic [KEY_W-1:0] k);
            logic [KEY_W-1:0] z;
            z = (k ^ (k >> MIX_SH0)) * MIX_C1;
            z = (z ^ (z >> MIX_SH1)) * MIX_C2;
            z = z ^ (z >> MIX_SH2);
            return int'(z % SLOTS);
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                                   logic [DATA_W-1:0] v);
            map_answer_t ans;
            int          hit;
            int          free_at;
            int          idx;
            bit          done;
            ans.status    = STAT_MISS;
            ans.value_out = '0;
            req_tally[op]++;
            if (op != REQ_UNUSED)
            begin
                hit     = -1;
                free_at = -1;
                done    = 1'b0;
                idx     = home_slot(k);
                // linear probe: stop at empty, at the key, or after one lap
                for (int i = 0; i < SLOTS && !done; i++)
                begin
                    if (slot_st[idx] == SLOT_EMPTY)
                    begin
                        if (free_at < 0)
                            free_at = idx;
                        done = 1'b1;
                    end
                    else if (slot_st[idx] == SLOT_USED)
                    begin
                        if (slot_key[idx] == k)
                        begin
                            hit  = idx;
                            done = 1'b1;
                        end
                    end
                    else if (free_at < 0)
                        free_at = idx;
                    if (!done)
                        idx = (idx + 1) % SLOTS;
                end
                case (op)
                    REQ_SET:
                    begin
                        if (hit >= 0)
                        begin
                            slot_val[hit] = v;
                            ans.status    = STAT_OK;
                        end
                        else if (occupied >= load_limit || free_at < 0)
                            ans.status = STAT_FULL;
                        else
                        begin
                            slot_st[free_at]  = SLOT_USED;
                            slot_key[free_at] = k;
                            slot_val[free_at] = v;
                            occupied++;
                            ans.status = STAT_OK;
                        end
                    end
                    REQ_GET:
                    begin
                        if (hit >= 0)
                        begin
                            ans.status    = STAT_OK;
                            ans.value_out = slot_val[hit];
                        end
                    end
                    default:
                    begin
                        if (hit >= 0)
                        begin
                            slot_st[hit] = SLOT_TOMB;
                            if (occupied > 0)
                                occupied--;
                            ans.status = STAT_OK;
                        end
                    end
                endcase
            end
            ans.entry_total = occupied;
            stat_tally[ans.status]++;
            answers_due.push_back(ans);
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("ERROR answer %0d %s: got 0x%0h, expected 0x%0h",
                     checked, field, got, want);
        endtask

        task check_response(map_answer_t got);
            map_answer_t want;
            checked++;
            if (answers_due.size() == 0)
                report("word with nothing outstanding", 64'(got), 64'(0));
            else
            begin
                want = answers_due.pop_front();
                if (got.status !== want.status)
                    report("status", 64'(got.status), 64'(want.status));
                if (got.value_out !== want.value_out)
                    report("value_out", 64'(got.value_out), 64'(want.value_out));
                if (got.entry_total !== want.entry_total)
                    report("entry_total", 64'(got.entry_total), 64'(want.entry_total));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    lphm_req_if req_ch ();
    lphm_rsp_if rsp_ch ();
    lphm_cfg_if cfg_ch ();

    hash_map_shadow sb = new();

    // stimulus knobs shared with the response side
    bit calm;            // no idling on either side while set
    bit rsp_hold_req;    // ask the response side for one long hold
    int stall_cycles;    // cycles since the last word moved on any channel

    logic [KEY_W-1:0] key_pool[$];

    linear_probe_hash_map_core #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // monitor: everything is sampled at the rising edge, inputs move on the
    // falling edge, so no sample races a drive
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // answers first: the word leaving now always belongs to an older request
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response({rsp_ch.status, rsp_ch.value_out, rsp_ch.entry_total});
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.req_type, req_ch.key, req_ch.value_in);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.load_limit = cfg_ch.load_limit;
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // response side: random back-pressure, plus one long hold on request
    // so that a finished request parks in the output register, the next
    // waits before applying and the core stops taking new words
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_hold_req = 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    // watchdog: ends the run if no word moves for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_CYCLES)
            @(posedge clk);
        $display("watchdog: no word moved for %0d cycles, %0d answers outstanding",
                 WATCHDOG_CYCLES, sb.pending());
        $display("linear_probe_hash_map_core: mismatch");
        $finish;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // a key whose home slot is the given one, different from two others
    function automatic logic [KEY_W-1:0] key_homed_at(int slot, logic [KEY_W-1:0] not_a,
                                                     logic [KEY_W-1:0] not_b);
        logic [KEY_W-1:0] k;
        do
            k = rand_key();
        while (sb.home_slot(k) != slot || k == not_a || k == not_b);
        return k;
    endfunction

    // mostly keys already seen, so that hits and removes find something
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        if (key_pool.size() == 0 || $urandom_range(0, 99) < 20)
        begin
            k = rand_key();
            if (key_pool.size() < KEY_POOL_MAX)
                key_pool.push_back(k);
            else
                key_pool[$urandom_range(0, KEY_POOL_MAX - 1)] = k;
        end
        else
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        return k;
    endfunction

    // offer one request word; starts and ends at a falling edge, valid
    // is left high and changed only by the next call or by quiesce
    task automatic send_request(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k,
                                input logic [DATA_W-1:0] v);
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.key      <= k;
        req_ch.value_in <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait until every answer has come back
    task automatic quiesce();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_load_limit(input logic [CNT_W-1:0] lim);
        quiesce();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.load_limit <= lim;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count, input int hold_at);
        int               r;
        logic [REQ_W-1:0] op;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = REQ_SET;
            else if (r < 75)
                op = REQ_GET;
            else if (r < 95)
                op = REQ_REMOVE;
            else
                op = REQ_UNUSED;
            if (n == hold_at)
                rsp_hold_req = 1'b1;
            send_request(op, pick_key(), $urandom);
        end
    endtask

    initial
    begin
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        logic [KEY_W-1:0] kc;
        logic [KEY_W-1:0] last_fill;

        // every input known from time zero
        rst_n             = 1'b0;
        calm              = 1'b0;
        rsp_hold_req      = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_SET;
        req_ch.key        = '0;
        req_ch.value_in   = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.load_limit = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // three keys sharing the last home slot, so the probe wraps to slot 0
        ka = key_homed_at(SLOTS - 1, '0, '0);
        kb = key_homed_at(SLOTS - 1, ka, ka);
        kc = key_homed_at(SLOTS - 1, ka, kb);

        // directed part at the reset load limit; the first word also waits
        // out the clearing pass
        send_request(REQ_GET, '0, '1);                     // miss on an empty map
        send_request(REQ_REMOVE, '1, '0);                  // remove of a missing key
        send_request(REQ_UNUSED, '0, '1);                  // unused code: no change
        send_request(REQ_SET, '0, '0);                     // smallest key and value
        send_request(REQ_SET, '1, '1);                     // largest key and value
        send_request(REQ_GET, '0, '0);
        send_request(REQ_GET, '1, '0);
        send_request(REQ_SET, '1, 32'h1234_5678);          // overwrite
        send_request(REQ_GET, '1, '0);
        send_request(REQ_SET, ka, 32'hA5A5_0001);          // lands in the last slot
        send_request(REQ_SET, kb, 32'h5A5A_0002);          // wraps around to slot 0
        send_request(REQ_GET, kb, '0);
        send_request(REQ_REMOVE, ka, '0);                  // leaves a tombstone
        send_request(REQ_GET, kb, '0);                     // probe steps over it
        send_request(REQ_SET, kb, 32'hDEAD_BEEF);          // hit found past the tombstone
        send_request(REQ_SET, kc, 32'h0BAD_F00D);          // new key reuses the tombstone
        send_request(REQ_GET, kc, '0);
        send_request(REQ_REMOVE, ka, '0);                  // already gone
        send_request(REQ_REMOVE, kb, '0);
        send_request(REQ_REMOVE, '0, '0);

        // smallest limit: count already above it, new keys refused
        write_load_limit(9'd1);
        send_request(REQ_SET, ka, 32'h1111_1111);          // refused, map full
        send_request(REQ_SET, '1, 32'h2222_2222);          // existing key still updates
        send_request(REQ_REMOVE, '1, '0);
        send_request(REQ_REMOVE, kc, '0);
        send_request(REQ_SET, ka, 32'h3333_3333);          // count back to the limit
        send_request(REQ_SET, kb, 32'h4444_4444);          // refused
        random_traffic(40, -1);

        // small limit with no idling on either side
        write_load_limit(9'd8);
        calm = 1'b1;
        random_traffic(150, -1);
        calm = 1'b0;

        // back to the usual three-quarter load, with one long response hold
        write_load_limit(LOAD_LIMIT_RST);
        random_traffic(500, 200);

        // largest limit: fill every slot, then work a map with no empty slot
        write_load_limit(9'd256);
        last_fill = '0;
        while (sb.occupied < SLOTS)
        begin
            last_fill = rand_key();
            send_request(REQ_SET, last_fill, $urandom);
        end
        send_request(REQ_SET, rand_key(), $urandom);       // no free slot at all
        send_request(REQ_GET, rand_key(), '0);             // miss after a full lap
        send_request(REQ_REMOVE, last_fill, '0);
        send_request(REQ_SET, rand_key(), $urandom);       // full lap, takes the tombstone
        send_request(REQ_SET, rand_key(), $urandom);       // full again
        random_traffic(300, -1);

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d set, %0d get, %0d remove, %0d unused code;",
                 sb.req_tally[REQ_SET] + sb.req_tally[REQ_GET] +
                 sb.req_tally[REQ_REMOVE] + sb.req_tally[REQ_UNUSED],
                 sb.req_tally[REQ_SET], sb.req_tally[REQ_GET],
                 sb.req_tally[REQ_REMOVE], sb.req_tally[REQ_UNUSED]);
        $display("load limits 192, 1, 8, 192, 256; answers ok %0d, not found %0d, full %0d",
                 sb.stat_tally[STAT_OK], sb.stat_tally[STAT_MISS],
                 sb.stat_tally[STAT_FULL]);
        if (sb.mismatches == 0)
            $display("linear_probe_hash_map_core: match");
        else
            $display("linear_probe_hash_map_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
